[src/ipv4_forward_classifier_assert.svh]
// assertion macros used by the checker file
`ifndef IPV4_FORWARD_CLASSIFIER_ASSERT_SVH
`define IPV4_FORWARD_CLASSIFIER_ASSERT_SVH

// assertion sampled on clk, off while reset is held
`define IFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion sampled on clk, also checked during reset
`define IFC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ifc_pkg.sv]
package ifc_pkg;

  // request payloads
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ifc_in_t;

  typedef struct packed {
    logic       forward;
    logic [1:0] match_class;
  } ifc_out_t;

  // captured header fields of the frame in flight
  typedef struct packed {
    logic [15:0] ether_type;
    logic [12:0] fragment_offset;
    logic [7:0]  ip_protocol;
    logic [15:0] source_port;
    logic [15:0] destination_port;
  } ifc_cap_t;

  localparam int unsigned POS_W     = 6;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned PORT_W    = 16;

  // byte positions within the frame
  localparam logic [POS_W-1:0] POS_ETYPE_HI = 6'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO = 6'd13;
  localparam logic [POS_W-1:0] POS_FRAG_HI  = 6'd20;
  localparam logic [POS_W-1:0] POS_FRAG_LO  = 6'd21;
  localparam logic [POS_W-1:0] POS_PROTO    = 6'd23;
  localparam logic [POS_W-1:0] POS_SPORT_HI = 6'd34;
  localparam logic [POS_W-1:0] POS_SPORT_LO = 6'd35;
  localparam logic [POS_W-1:0] POS_DPORT_HI = 6'd36;
  localparam logic [POS_W-1:0] POS_DPORT_LO = 6'd37;
  localparam logic [POS_W-1:0] POS_MAX      = 6'd63;

  // protocol constants
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // match class codes
  localparam logic [1:0] CLS_NONE = 2'd0;
  localparam logic [1:0] CLS_FRAG = 2'd1;
  localparam logic [1:0] CLS_UDP  = 2'd2;
  localparam logic [1:0] CLS_TCP  = 2'd3;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_PORT_FIRST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_SECOND = 8'd1;
  localparam logic [PORT_W-1:0]    PORT_FIRST_RST  = 16'd5060;
  localparam logic [PORT_W-1:0]    PORT_SECOND_RST = 16'd15070;

endpackage

[src/ipv4_forward_classifier.sv]
// Ethernet frame filter: takes one frame byte per request, from the first byte of the
// destination address, and gives one verdict request per frame when the byte marked last
// has gone through. It keeps the ethertype, IPv4 fragment offset, protocol and UDP ports
// (fixed 20-byte IP header), and forwards IPv4 later fragments, UDP datagrams whose source
// or destination port equals one of the two configured ports, and TCP segments. A byte is
// accepted every cycle while input is not held back; the last byte waits in the input
// register until the capture and compare logic loads the verdict into the result
// register. Only a verdict that waits on out_ready while the next last byte is
// already in the input register holds back input. Configuration writes are taken at once.
module ipv4_forward_classifier
  import ifc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ifc_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ifc_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PORT_W-1:0]    cfg_data
);

  logic              s1_valid_r;
  ifc_in_t           s1_data_r;
  logic              s1_adv;
  logic              out_load;
  logic [PORT_W-1:0] port_first_r;
  logic [PORT_W-1:0] port_second_r;
  ifc_cap_t          cap_nxt;
  ifc_out_t          verdict;

  // stage advance: non-last bytes always move, last byte needs a free result slot
  assign s1_adv   = s1_valid_r && (!s1_data_r.last_byte || !out_valid || out_ready);
  assign out_load = s1_adv && s1_data_r.last_byte;
  assign in_ready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_first_r  <= PORT_FIRST_RST;
      port_second_r <= PORT_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PORT_FIRST) begin
        port_first_r <= cfg_data;
      end
      if (cfg_index == REG_PORT_SECOND) begin
        port_second_r <= cfg_data;
      end
    end
  end

  ifc_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (s1_adv),
    .data_byte (s1_data_r.data_byte),
    .last_byte (s1_data_r.last_byte),
    .cap_nxt   (cap_nxt)
  );

  ifc_verdict u_verdict (
    .cap         (cap_nxt),
    .port_first  (port_first_r),
    .port_second (port_second_r),
    .verdict     (verdict)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= verdict;
    end
  end

endmodule

[src/ifc_capture.sv]
module ifc_capture
  import ifc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output ifc_cap_t   cap_nxt
);

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  ifc_cap_t         cap_r;

  // merge the current byte into the captured fields
  always_comb begin
    cap_nxt = cap_r;
    case (pos_r)
      POS_ETYPE_HI: cap_nxt.ether_type[15:8] = data_byte;
      POS_ETYPE_LO: cap_nxt.ether_type[7:0] = data_byte;
      POS_FRAG_HI:  cap_nxt.fragment_offset[12:8] = data_byte[4:0];
      POS_FRAG_LO:  cap_nxt.fragment_offset[7:0] = data_byte;
      POS_PROTO:    cap_nxt.ip_protocol = data_byte;
      POS_SPORT_HI: cap_nxt.source_port[15:8] = data_byte;
      POS_SPORT_LO: cap_nxt.source_port[7:0] = data_byte;
      POS_DPORT_HI: cap_nxt.destination_port[15:8] = data_byte;
      POS_DPORT_LO: cap_nxt.destination_port[7:0] = data_byte;
      default:      cap_nxt = cap_r;
    endcase
  end

  // saturating byte counter
  assign pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;

  // capture state, cleared after the last byte of each frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cap_r <= '0;
    end else if (take) begin
      if (last_byte) begin
        pos_r <= '0;
        cap_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        cap_r <= cap_nxt;
      end
    end
  end

endmodule

[src/ifc_verdict.sv]
module ifc_verdict
  import ifc_pkg::*;
(
  input  ifc_cap_t          cap,
  input  logic [PORT_W-1:0] port_first,
  input  logic [PORT_W-1:0] port_second,
  output ifc_out_t          verdict
);

  logic is_ipv4;
  logic is_frag;
  logic port_hit;

  assign is_ipv4  = (cap.ether_type == ETHERTYPE_IPV4);
  assign is_frag  = (cap.fragment_offset != '0);
  assign port_hit = (cap.source_port == port_first) || (cap.source_port == port_second) ||
                    (cap.destination_port == port_first) ||
                    (cap.destination_port == port_second);

  // class in priority order: later fragment, udp port match, tcp
  always_comb begin
    verdict.match_class = CLS_NONE;
    if (is_ipv4) begin
      if (is_frag) begin
        verdict.match_class = CLS_FRAG;
      end else if ((cap.ip_protocol == PROTO_UDP) && port_hit) begin
        verdict.match_class = CLS_UDP;
      end else if (cap.ip_protocol == PROTO_TCP) begin
        verdict.match_class = CLS_TCP;
      end
    end
    verdict.forward = (verdict.match_class != CLS_NONE);
  end

endmodule

[src/ifc_checker.sv]
`include "ipv4_forward_classifier_assert.svh"

module ifc_checker
  import ifc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input ifc_out_t out_data,
  input logic     cfg_ready
);

  // no verdict request right after reset
  `IFC_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid, "out_valid high after reset")

  // a stalled verdict holds
  `IFC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "verdict changed while stalled")

  // forward agrees with the class code
  `IFC_ASSERT(a_fwd_class, out_valid |-> (out_data.forward == (out_data.match_class != CLS_NONE)), "forward and match_class disagree")

  // input is only held back by a stalled verdict
  `IFC_ASSERT(a_backpress, !in_ready |-> out_valid && !out_ready, "in_ready low without output stall")

  // configuration writes are never refused
  `IFC_ASSERT(a_cfg_ready, cfg_ready, "cfg_ready low")

endmodule

bind ipv4_forward_classifier ifc_checker u_ifc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);
